// ===== design/mfvn_pkg.sv =====
// Shared types and constants for the mesh face/vertex normal block.
package mfvn_pkg;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TRI  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  localparam logic KIND_FACE   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // Span of the 10-bit index fields.
  localparam int IDX_SPAN = 1024;
  localparam int IDX_W    = 10;

  localparam logic signed [24:0] SUM_MAX = 25'sd8388607;
  localparam logic signed [24:0] SUM_MIN = -25'sd8388608;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         vert_idx;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } sum_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       take;
    logic       red_step;
    logic       pos_wr;
    logic       sum_wr_zero;
    logic       clr_wr;
    logic       pos_rd;
    logic       pos_latch;
    logic       cross_mul;
    logic       cross_acc;
    logic       mag_face;
    logic       mag_sum;
    logic       shift;
    logic       sq_mul;
    logic       sq_acc;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_end;
    logic       set_deg;
    logic       sum_rd;
    logic       sum_wr_acc;
    logic       emit;
    logic [1:0] sel;
    logic [1:0] sel2;
    logic [2:0] mul_idx;
    logic [2:0] acc_idx;
    logic [3:0] step;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] act;
    logic       vec_zero;
    logic       norm_ok;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== design/mfvn_ctrl.sv =====
// Sequencing state machine for the normal block.
module mfvn_ctrl
  import mfvn_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dp_stat_t                          stat,
  output dp_cmd_t                           cmd,
  output logic [$clog2(MAX_VERTICES)-1:0]   clr_addr
);

  localparam int  AW       = $clog2(MAX_VERTICES);
  localparam int  CW       = (AW > 5) ? AW : 5;
  localparam bit  NEED_RED = (MAX_VERTICES < IDX_SPAN);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_DISPATCH, S_LOADW, S_PRD, S_CROSS, S_MAGF,
    S_SRD, S_MAGS, S_CHECK, S_SHIFT, S_SQ, S_SQRTI, S_SQRT, S_DIVI, S_DIV,
    S_DIVE, S_POST, S_ACCR, S_ACCW, S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    ci_r, ci_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign clr_addr = cnt_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ci_nxt    = ci_r;
    cmd       = '0;
    cmd.sel     = ci_r;
    cmd.sel2    = 2'(cnt_r[1:0] - 2'd1);
    cmd.mul_idx = cnt_r[2:0];
    cmd.acc_idx = 3'(cnt_r[2:0] - 3'd1);
    cmd.step    = 4'(4'd9 - 4'(cnt_r[3:0]));
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CW'(MAX_VERTICES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = NEED_RED ? S_REDUCE : S_DISPATCH;
        end
      end
      S_REDUCE: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(IDX_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_nxt = '0;
        ci_nxt  = '0;
        case (stat.act)
          ACT_LOAD: state_nxt = S_LOADW;
          ACT_TRI:  state_nxt = S_PRD;
          ACT_READ: state_nxt = S_SRD;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_LOADW: begin
        cmd.pos_wr      = 1'b1;
        cmd.sum_wr_zero = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_PRD: begin
        cmd.sel       = cnt_r[1:0];
        cmd.pos_rd    = (cnt_r < CW'(3));
        cmd.pos_latch = (cnt_r != '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_CROSS;
        end
      end
      S_CROSS: begin
        cmd.cross_mul = (cnt_r < CW'(6));
        cmd.cross_acc = (cnt_r != '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(6)) begin
          cnt_nxt   = '0;
          state_nxt = S_MAGF;
        end
      end
      S_MAGF: begin
        cmd.mag_face = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_SRD: begin
        cmd.sel    = 2'd0;
        cmd.sum_rd = 1'b1;
        state_nxt  = S_MAGS;
      end
      S_MAGS: begin
        cmd.mag_sum = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (stat.vec_zero) begin
          cmd.set_deg = 1'b1;
          state_nxt   = S_POST;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.norm_ok) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_SQ: begin
        cmd.sq_mul = (cnt_r < CW'(3));
        cmd.sq_acc = (cnt_r != '0);
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CW'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRTI;
        end
      end
      S_SQRTI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(31)) begin
          cnt_nxt   = '0;
          ci_nxt    = '0;
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(14)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIVE;
        end
      end
      S_DIVE: begin
        cmd.div_end = 1'b1;
        if (ci_r == 2'd2) begin
          state_nxt = S_POST;
        end else begin
          ci_nxt    = ci_r + 2'd1;
          state_nxt = S_DIVI;
        end
      end
      S_POST: begin
        ci_nxt    = '0;
        state_nxt = (stat.act == ACT_TRI) ? S_ACCR : S_EMIT;
      end
      S_ACCR: begin
        cmd.sum_rd = 1'b1;
        state_nxt  = S_ACCW;
      end
      S_ACCW: begin
        cmd.sum_wr_acc = 1'b1;
        if (ci_r == 2'd2) begin
          state_nxt = S_EMIT;
        end else begin
          ci_nxt    = ci_r + 2'd1;
          state_nxt = S_ACCR;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      ci_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ci_r    <= ci_nxt;
    end
  end

endmodule

// ===== design/mfvn_dp.sv =====
// Datapath: vertex and sum memories, shared multiplier, sqrt and divider.
module mfvn_dp
  import mfvn_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  in_item_t                        in_data,
  input  dp_cmd_t                         cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0] clr_addr,
  output dp_stat_t                        stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output out_item_t                       out_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [19:0] MAXW = 20'(MAX_VERTICES);

  pos_t       pos_mem [MAX_VERTICES];
  sum_t       sum_mem [MAX_VERTICES];

  logic [1:0]         act_r;
  pos_t               coord_r;
  logic [9:0]         idx_r [3];
  pos_t               pos_rd_r;
  pos_t               corner_r [3];
  sum_t               sum_rd_r;
  logic signed [63:0] prod_r;
  logic signed [35:0] comp_r [3];
  logic [35:0]        mag_r [3];
  logic               neg_r [3];
  logic [63:0]        sq_r;
  logic [63:0]        sv_r, sr_r, sb_r;
  logic [31:0]        rem_r;
  logic [14:0]        nlo_r;
  logic [14:0]        q_r;
  logic signed [15:0] nrm_r [3];
  logic               deg_r;
  logic               out_valid_r;
  out_item_t          out_r;

  function automatic logic [AW-1:0] to_addr(input logic [9:0] v);
    logic [AW+9:0] t;
    t = {{AW{1'b0}}, v};
    return t[AW-1:0];
  endfunction

  function automatic logic signed [23:0] sat_add(input logic signed [23:0] s,
                                                  input logic signed [15:0] n);
    logic signed [24:0] r;
    r = {s[23], s} + {{9{n[15]}}, n};
    if (r > SUM_MAX) return 24'sh7FFFFF;
    else if (r < SUM_MIN) return 24'sh800000;
    else return r[23:0];
  endfunction

  // Edges from corner a.
  logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
  always_comb begin
    e1x = {corner_r[1].x[15], corner_r[1].x} - {corner_r[0].x[15], corner_r[0].x};
    e1y = {corner_r[1].y[15], corner_r[1].y} - {corner_r[0].y[15], corner_r[0].y};
    e1z = {corner_r[1].z[15], corner_r[1].z} - {corner_r[0].z[15], corner_r[0].z};
    e2x = {corner_r[2].x[15], corner_r[2].x} - {corner_r[0].x[15], corner_r[0].x};
    e2y = {corner_r[2].y[15], corner_r[2].y} - {corner_r[0].y[15], corner_r[0].y};
    e2z = {corner_r[2].z[15], corner_r[2].z} - {corner_r[0].z[15], corner_r[0].z};
  end

  // Shared multiplier operand select.
  logic signed [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sq_mul) begin
      mul_a = {2'b00, mag_r[cmd.mul_idx[1:0]][29:0]};
      mul_b = {2'b00, mag_r[cmd.mul_idx[1:0]][29:0]};
    end else begin
      case (cmd.mul_idx)
        3'd0: begin mul_a = 32'(e1y); mul_b = 32'(e2z); end
        3'd1: begin mul_a = 32'(e1z); mul_b = 32'(e2y); end
        3'd2: begin mul_a = 32'(e1z); mul_b = 32'(e2x); end
        3'd3: begin mul_a = 32'(e1x); mul_b = 32'(e2z); end
        3'd4: begin mul_a = 32'(e1x); mul_b = 32'(e2y); end
        3'd5: begin mul_a = 32'(e1y); mul_b = 32'(e2x); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  logic [35:0] big;
  always_comb begin
    big = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    if (mag_r[2] > big) big = mag_r[2];
  end

  logic [19:0]  red_lim;
  logic [63:0]  sq_try;
  logic [44:0]  div_num;
  logic [32:0]  div_t;
  logic         div_ge;
  logic [15:0]  q_ext;
  logic [31:0]  len;
  sum_t         sum_new;
  logic [AW-1:0] sum_wa;
  sum_t         sum_wd;
  logic         sum_we;

  always_comb begin
    red_lim = MAXW << cmd.step;
    sq_try  = sr_r + sb_r;
    len     = sr_r[31:0];
    div_num = {1'b0, mag_r[cmd.sel][29:0], 14'd0} + 45'(len >> 1);
    div_t   = {rem_r, nlo_r[14]};
    div_ge  = (div_t >= {1'b0, len});
    q_ext   = {1'b0, q_r};
    sum_new.x = sat_add(sum_rd_r.x, nrm_r[0]);
    sum_new.y = sat_add(sum_rd_r.y, nrm_r[1]);
    sum_new.z = sat_add(sum_rd_r.z, nrm_r[2]);
    sum_we = cmd.clr_wr | cmd.sum_wr_zero | cmd.sum_wr_acc;
    sum_wa = cmd.clr_wr ? clr_addr : to_addr(idx_r[cmd.sel]);
    sum_wd = cmd.sum_wr_acc ? sum_new : '0;
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.pos_wr) pos_mem[to_addr(idx_r[0])] <= coord_r;
    if (cmd.pos_rd) pos_rd_r <= pos_mem[to_addr(idx_r[cmd.sel])];
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (cmd.sum_rd) sum_rd_r <= sum_mem[to_addr(idx_r[cmd.sel])];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_r     <= in_data.action;
      coord_r.x <= in_data.coord_x;
      coord_r.y <= in_data.coord_y;
      coord_r.z <= in_data.coord_z;
      idx_r[0]  <= (in_data.action == ACT_TRI) ? in_data.corner_a : in_data.vert_idx;
      idx_r[1]  <= in_data.corner_b;
      idx_r[2]  <= in_data.corner_c;
    end
    // Restoring reduction of the indices modulo the store depth.
    if (cmd.red_step) begin
      for (int j = 0; j < 3; j++) begin
        if ({10'd0, idx_r[j]} >= red_lim) idx_r[j] <= idx_r[j] - red_lim[9:0];
      end
    end
    if (cmd.pos_latch) corner_r[cmd.sel2] <= pos_rd_r;
    if (cmd.cross_mul || cmd.sq_mul) prod_r <= mul_a * mul_b;
    if (cmd.cross_acc) begin
      if (!cmd.acc_idx[0]) comp_r[cmd.acc_idx[2:1]] <= prod_r[35:0];
      else comp_r[cmd.acc_idx[2:1]] <= comp_r[cmd.acc_idx[2:1]] - prod_r[35:0];
    end
    if (cmd.mag_face) begin
      for (int j = 0; j < 3; j++) begin
        neg_r[j] <= comp_r[j][35];
        mag_r[j] <= comp_r[j][35] ? 36'(-comp_r[j]) : 36'(comp_r[j]);
      end
    end
    if (cmd.mag_sum) begin
      neg_r[0] <= sum_rd_r.x[23];
      neg_r[1] <= sum_rd_r.y[23];
      neg_r[2] <= sum_rd_r.z[23];
      mag_r[0] <= sum_rd_r.x[23] ? 36'(-36'(sum_rd_r.x)) : 36'(sum_rd_r.x);
      mag_r[1] <= sum_rd_r.y[23] ? 36'(-36'(sum_rd_r.y)) : 36'(sum_rd_r.y);
      mag_r[2] <= sum_rd_r.z[23] ? 36'(-36'(sum_rd_r.z)) : 36'(sum_rd_r.z);
    end
    if (cmd.mag_face || cmd.mag_sum) deg_r <= 1'b0;
    // Scale the largest magnitude into [2^29, 2^30).
    if (cmd.shift) begin
      for (int j = 0; j < 3; j++) begin
        if (|big[35:30]) mag_r[j] <= mag_r[j] >> 1;
        else if (big[29:22] == 8'd0) mag_r[j] <= mag_r[j] << 8;
        else mag_r[j] <= mag_r[j] << 1;
      end
    end
    if (cmd.sq_acc) sq_r <= (cmd.acc_idx == 3'd0) ? 64'(prod_r) : sq_r + 64'(prod_r);
    if (cmd.sqrt_init) begin
      sv_r <= sq_r;
      sr_r <= '0;
      sb_r <= 64'd1 << 62;
    end
    if (cmd.sqrt_step) begin
      if (sv_r >= sq_try) begin
        sv_r <= sv_r - sq_try;
        sr_r <= (sr_r >> 1) + sb_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sb_r <= sb_r >> 2;
    end
    if (cmd.div_init) begin
      rem_r <= 32'(div_num[44:15]);
      nlo_r <= div_num[14:0];
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? 32'(div_t - {1'b0, len}) : div_t[31:0];
      nlo_r <= {nlo_r[13:0], 1'b0};
      q_r   <= {q_r[13:0], div_ge};
    end
    if (cmd.div_end) nrm_r[cmd.sel] <= neg_r[cmd.sel] ? 16'(-q_ext) : q_ext;
    if (cmd.set_deg) begin
      deg_r <= 1'b1;
      for (int j = 0; j < 3; j++) nrm_r[j] <= '0;
    end
    if (cmd.emit) begin
      out_r.result_kind <= (act_r == ACT_READ) ? KIND_VERTEX : KIND_FACE;
      out_r.normal_x    <= nrm_r[0];
      out_r.normal_y    <= nrm_r[1];
      out_r.normal_z    <= nrm_r[2];
      out_r.degenerate  <= deg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.act      = act_r;
  assign stat.vec_zero = (big == '0);
  assign stat.norm_ok  = (big[35:30] == '0) && big[29];
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

// ===== design/mesh_face_vertex_normals.sv =====
// Top level: triangle mesh face and per-vertex normals in fixed point.
//
// Input channel (in_valid/in_stall/in_data) takes one request at a time:
// load a vertex, add a triangle, or read a vertex normal. A load writes the
// position and zeroes that vertex's normal sum and returns nothing. A
// triangle returns its unit face normal (Q1.14) and adds it to the sums of
// its three corners; a read returns the normalized sum of one vertex.
// Result channel (out_valid/out_stall/out_data) carries one result per
// triangle or read; a zero-length vector comes back as zero with degenerate.
// A triangle or read runs the 32-step square root and three 15-step
// divisions on one shared datapath; a zero-length vector skips them.
// With MAX_VERTICES below 1024, indices are first reduced modulo the
// depth before the request is dispatched.
// Reset: a clearing pass zeroes the sum memory with in_stall high. A
// finished result waits in the output register while out_stall is high;
// the next request can be taken and worked on meanwhile, holding only
// before its own result is written.
module mesh_face_vertex_normals
  import mfvn_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t                         cmd;
  dp_stat_t                        stat;
  logic [$clog2(MAX_VERTICES)-1:0] clr_addr;

  mfvn_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd),
    .clr_addr (clr_addr)
  );

  mfvn_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .clr_addr  (clr_addr),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
